// File: hdl/jlvsr_pkg.sv
// shared types and constants for the jerk limited velocity and steering ramp
package jlvsr_pkg;

   localparam int CSR_INDEX_WIDTH = 4;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BRAKE_JERK_STEP   = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BRAKE_ACCEL_LIMIT = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCEL_JERK_STEP   = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCEL_LIMIT       = 4'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DECEL_JERK_STEP   = 4'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DECEL_LIMIT       = 4'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TICK_PERIOD       = 4'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEER_OFFSET      = 4'd7;

   // ramp modes
   localparam logic [1:0] MODE_BRAKE         = 2'd0;
   localparam logic [1:0] MODE_BRAKE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_ACCELERATE    = 2'd2;
   localparam logic [1:0] MODE_DECELERATE    = 2'd3;

   // steering rate schedule, Q16
   localparam logic [16:0] VMIN_Q    = 17'd36409;
   localparam logic [16:0] VSPAN_Q   = 17'd91022;
   localparam logic [15:0] RATE_LO_Q = 16'd16013;
   localparam logic [15:0] RATE_HI_Q = 16'd41178;
   localparam logic [14:0] SLOPE_Q   = 15'd18118;

   typedef struct packed {
      logic signed [23:0] target_speed;
      logic signed [23:0] target_steer;
      logic signed [23:0] measured_speed;
   } req_type;

   typedef struct packed {
      logic signed [23:0] speed_setpoint;
      logic signed [23:0] accel_command;
      logic signed [23:0] steer_command;
      logic               braking;
      logic signed [23:0] speed_error;
      logic [22:0]        forward_target;
      logic [1:0]         ramp_mode;
   } rsp_type;

   typedef struct packed {
      logic [22:0]        brake_jerk_step;
      logic [22:0]        brake_accel_limit;
      logic [22:0]        accel_jerk_step;
      logic [22:0]        accel_limit;
      logic [22:0]        decel_jerk_step;
      logic [22:0]        decel_limit;
      logic [22:0]        tick_period;
      logic signed [23:0] steer_offset;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mode_step;
      logic mul_step;
      logic ramp_step;
      logic steer_step;
      logic commit;
   } ctrl_cmd_type;

endpackage

// File: hdl/jlvsr_csr.sv
// configuration register file
module jlvsr_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [jlvsr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [23:0]                            csr_data,
   output jlvsr_pkg::cfg_type                     cfg
);

   jlvsr_pkg::cfg_type cfg_ff;
   jlvsr_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            jlvsr_pkg::CSR_BRAKE_JERK_STEP:   cfg_in.brake_jerk_step   = csr_data[22:0];
            jlvsr_pkg::CSR_BRAKE_ACCEL_LIMIT: cfg_in.brake_accel_limit = csr_data[22:0];
            jlvsr_pkg::CSR_ACCEL_JERK_STEP:   cfg_in.accel_jerk_step   = csr_data[22:0];
            jlvsr_pkg::CSR_ACCEL_LIMIT:       cfg_in.accel_limit       = csr_data[22:0];
            jlvsr_pkg::CSR_DECEL_JERK_STEP:   cfg_in.decel_jerk_step   = csr_data[22:0];
            jlvsr_pkg::CSR_DECEL_LIMIT:       cfg_in.decel_limit       = csr_data[22:0];
            jlvsr_pkg::CSR_TICK_PERIOD:       cfg_in.tick_period       = csr_data[22:0];
            jlvsr_pkg::CSR_STEER_OFFSET:      cfg_in.steer_offset      = $signed(csr_data);
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/jlvsr_ctrl.sv
// sequencing state machine for one tick
module jlvsr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output jlvsr_pkg::ctrl_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MODE  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_RAMP  = 3'd3;
   localparam logic [2:0] ST_STEER = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_MODE;
         end
         ST_MODE: begin
            cmd.mode_step = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = ST_RAMP;
         end
         ST_RAMP: begin
            cmd.ramp_step = 1'b1;
            state_in      = ST_STEER;
         end
         ST_STEER: begin
            cmd.steer_step = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/jlvsr_datapath.sv
// ramp datapath: mode select, jerk step, integration, steering rate
module jlvsr_datapath #(
   parameter int VALUE_WIDTH = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  jlvsr_pkg::ctrl_cmd_type cmd,
   input  jlvsr_pkg::req_type      req,
   input  jlvsr_pkg::cfg_type      cfg,
   output jlvsr_pkg::rsp_type      rsp
);

   localparam int W  = VALUE_WIDTH;
   localparam int XW = ((W > 24) ? W : 24) + 10;
   localparam int PW = W + 24;
   localparam logic signed [XW-1:0] MAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [XW-1:0] MIN_X = ~MAX_X;

   function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
      logic signed [W-1:0] r;
      if (v > MAX_X) r = MAX_X[W-1:0];
      else if (v < MIN_X) r = MIN_X[W-1:0];
      else r = v[W-1:0];
      return r;
   endfunction

   function automatic logic signed [XW-1:0] ext(input logic signed [W-1:0] v);
      return XW'(v);
   endfunction

   function automatic logic signed [XW-1:0] uext(input logic [22:0] v);
      return $signed(XW'(v));
   endfunction

   // working registers
   logic signed [W-1:0]  tgt_ff, wz_ff, meas_ff;
   logic signed [W-1:0]  speed_ff, steer_ff, accel_ff;
   logic [1:0]           mode_ff;
   logic [1:0]           mode_new_ff, mode_new_in;
   logic                 act_ff, act_in;
   logic                 up_ff, up_in;
   logic signed [W-1:0]  accel_new_ff, accel_new_in;
   logic [31:0]          slope_prod_ff, slope_prod_in;
   logic signed [PW-1:0] pa_ff, pa_in;
   logic [15:0]          rate_ff, rate_in;
   logic signed [W-1:0]  speed_new_ff, speed_new_in;
   logic [38:0]          pd_ff, pd_in;
   logic signed [W-1:0]  steer_new_ff, steer_new_in;
   jlvsr_pkg::rsp_type   rsp_ff, rsp_in;

   // mode step temporaries
   logic signed [XW-1:0] step_x, lim_x, base_x, dv_x;
   logic signed [W-1:0]  acc_t, acc_c;
   logic [16:0]          dv;

   always_comb begin
      mode_new_in = mode_ff;
      act_in      = 1'b1;
      up_in       = 1'b0;
      step_x      = '0;
      lim_x       = '0;
      if (tgt_ff < 0) begin
         mode_new_in = jlvsr_pkg::MODE_BRAKE;
         step_x      = -uext(cfg.brake_jerk_step);
         lim_x       = uext(cfg.brake_accel_limit);
      end else if (tgt_ff > 0 && speed_ff < 0) begin
         mode_new_in = jlvsr_pkg::MODE_BRAKE_RELEASE;
         step_x      = uext(cfg.brake_jerk_step);
         lim_x       = uext(cfg.brake_accel_limit);
         up_in       = 1'b1;
      end else if (tgt_ff > speed_ff) begin
         mode_new_in = jlvsr_pkg::MODE_ACCELERATE;
         step_x      = uext(cfg.accel_jerk_step);
         lim_x       = uext(cfg.accel_limit);
         up_in       = 1'b1;
      end else if (tgt_ff < speed_ff) begin
         mode_new_in = jlvsr_pkg::MODE_DECELERATE;
         step_x      = -uext(cfg.decel_jerk_step);
         lim_x       = uext(cfg.decel_limit);
      end else begin
         act_in = 1'b0;
      end
      // acceleration restarts from zero on a mode change
      base_x = (mode_new_in != mode_ff) ? '0 : ext(accel_ff);
      acc_t  = sat_w(base_x + step_x);
      acc_c  = acc_t;
      if (up_in) begin
         if (ext(acc_t) > lim_x) acc_c = sat_w(lim_x);
      end else begin
         if (ext(acc_t) < -lim_x) acc_c = sat_w(-lim_x);
      end
      accel_new_in = act_in ? acc_c : accel_ff;

      dv_x = ext(meas_ff) - $signed(XW'(jlvsr_pkg::VMIN_Q));
      if (dv_x < 0) dv = '0;
      else if (dv_x > $signed(XW'(jlvsr_pkg::VSPAN_Q))) dv = jlvsr_pkg::VSPAN_Q;
      else dv = dv_x[16:0];
      slope_prod_in = 32'(jlvsr_pkg::SLOPE_Q) * 32'(dv);
   end

   // multiply step
   logic [16:0]        rate_drop;
   logic signed [17:0] rate_t;

   always_comb begin
      pa_in     = PW'(accel_new_ff) * PW'($signed({1'b0, cfg.tick_period}));
      rate_drop = 17'((slope_prod_ff + 32'd32768) >> 16);
      rate_t    = $signed({2'b00, jlvsr_pkg::RATE_HI_Q}) - $signed({1'b0, rate_drop});
      if (rate_t < $signed({2'b00, jlvsr_pkg::RATE_LO_Q})) rate_in = jlvsr_pkg::RATE_LO_Q;
      else rate_in = rate_t[15:0];
   end

   // integration step, round half up then floor
   logic signed [PW-1:0] pa_rnd;
   logic signed [PW-1:0] pa_shift;
   logic signed [W-1:0]  spd_t;

   always_comb begin
      pa_rnd   = pa_ff + $signed(PW'(32768));
      pa_shift = pa_rnd >>> 16;
      spd_t    = sat_w(ext(speed_ff) + XW'(pa_shift));
      if (up_ff) begin
         if (spd_t > tgt_ff) spd_t = tgt_ff;
      end else begin
         if (spd_t < tgt_ff) spd_t = tgt_ff;
      end
      speed_new_in = act_ff ? spd_t : speed_ff;
      pd_in        = 39'(rate_ff) * 39'(cfg.tick_period);
   end

   // steering ramp step
   logic [23:0]          delta;
   logic signed [XW-1:0] delta_x;
   logic signed [W-1:0]  str_t;

   always_comb begin
      delta   = 24'((pd_ff + 39'd32768) >> 16);
      delta_x = $signed(XW'(delta));
      str_t   = steer_ff;
      if (wz_ff > steer_ff) begin
         str_t = sat_w(ext(steer_ff) + delta_x);
         if (str_t > wz_ff) str_t = wz_ff;
      end else if (wz_ff < steer_ff) begin
         str_t = sat_w(ext(steer_ff) - delta_x);
         if (str_t < wz_ff) str_t = wz_ff;
      end
      steer_new_in = str_t;
   end

   // result word
   logic signed [W-1:0] offs;

   always_comb begin
      offs                  = sat_w(XW'(cfg.steer_offset));
      rsp_in.speed_setpoint = 24'(speed_new_ff);
      rsp_in.accel_command  = 24'(accel_new_ff);
      rsp_in.steer_command  = 24'(sat_w(ext(offs) + ext(steer_new_ff)));
      rsp_in.braking        = (speed_new_ff < 0);
      rsp_in.speed_error    = 24'(sat_w(ext(speed_new_ff) - ext(meas_ff)));
      rsp_in.forward_target = (speed_new_ff > 0) ? 23'(speed_new_ff) : '0;
      rsp_in.ramp_mode      = mode_new_ff;
   end

   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tgt_ff  <= sat_w(XW'(req.target_speed));
         wz_ff   <= sat_w(XW'(req.target_steer));
         meas_ff <= sat_w(XW'(req.measured_speed));
      end
      if (cmd.mode_step) begin
         mode_new_ff   <= mode_new_in;
         act_ff        <= act_in;
         up_ff         <= up_in;
         accel_new_ff  <= accel_new_in;
         slope_prod_ff <= slope_prod_in;
      end
      if (cmd.mul_step) begin
         pa_ff   <= pa_in;
         rate_ff <= rate_in;
      end
      if (cmd.ramp_step) begin
         speed_new_ff <= speed_new_in;
         pd_ff        <= pd_in;
      end
      if (cmd.steer_step) begin
         steer_new_ff <= steer_new_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // ramp state
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
         steer_ff <= '0;
         accel_ff <= '0;
         mode_ff  <= jlvsr_pkg::MODE_BRAKE;
      end else if (cmd.commit) begin
         speed_ff <= speed_new_ff;
         steer_ff <= steer_new_ff;
         accel_ff <= accel_new_ff;
         mode_ff  <= mode_new_ff;
      end
   end

endmodule

// File: hdl/jerk_limited_velocity_steer_ramp_top.sv
// top level of the jerk limited velocity and rate limited steering ramp
//
//   channel   ports                        direction   moves
//   req       req_valid/req_ready/req      in          one word per control tick
//   rsp       rsp_valid/rsp_ready/rsp      out         one word per accepted req word
//   csr       csr_valid/csr_ready/index    in          one register write, always ready
//
// the accepting edge loads the word; the sequencer then steps through mode select,
// multiply, integrate, steering step and commit, and rsp_valid rises with the commit.
// a new req word is taken as soon as the sequencer is back in idle, even while
// the previous result still waits; commit then stalls until rsp is taken.
// reset clears the ramp state, the mode (brake), the configuration and the sequencer;
// the working registers and the held result word are not reset.
module jerk_limited_velocity_steer_ramp_top #(
   parameter int VALUE_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  jlvsr_pkg::req_type                    req,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output jlvsr_pkg::rsp_type                    rsp,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [jlvsr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [23:0]                           csr_data
);

   jlvsr_pkg::cfg_type      cfg;
   jlvsr_pkg::ctrl_cmd_type cmd;

   jlvsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   jlvsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   jlvsr_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req),
      .cfg   (cfg),
      .rsp   (rsp)
   );

endmodule

// File: hdl/jlvsr_checker.sv
// port level checks for the ramp block, bound to the top level
module jlvsr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input jlvsr_pkg::rsp_type rsp
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp word changed while stalled");

   // one word in flight: no second accept right after the first
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while busy");

   // a result appears only out of a busy period
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("rsp valid without work in progress");

   // braking means no forward target
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.braking |-> rsp.forward_target == '0)
      else $error("forward target nonzero while braking");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind jerk_limited_velocity_steer_ramp_top jlvsr_checker u_jlvsr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);

// File: verif/tb_jerk_limited_velocity_steer_ramp_top.sv
// self-checking testbench for the jerk limited velocity and steering ramp top level
module tb_jerk_limited_velocity_steer_ramp_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIR_ROWS        = 23;
   localparam int RANDOM_PHASES   = 5;
   localparam int PHASE_ITEMS     = 185;
   localparam int SETTLE_CYCLES   = 8;
   localparam int STALL_LIMIT     = 2000;
   localparam int PRESSURE_AT     = 400;
   localparam int PRESSURE_CYCLES = 160;
   localparam int IDX_W           = jlvsr_pkg::CSR_INDEX_WIDTH;

   localparam logic [IDX_W-1:0] CSR_SPARE_LO = 4'd8;
   localparam logic [IDX_W-1:0] CSR_SPARE_HI = 4'd15;

   localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] Q_MIN = 24'sh800000;
   localparam longint VAL_MAX = 64'sd8388607;
   localparam longint VAL_MIN = -64'sd8388608;

   typedef struct packed {
      logic               reconfig;
      logic               typed;
      jlvsr_pkg::req_type word;
      jlvsr_pkg::rsp_type want;
   } stim_row_type;

   localparam jlvsr_pkg::cfg_type SET_A = '{23'h002000, 23'h010000, 23'h004000, 23'h020000,
                                            23'h003000, 23'h018000, 23'h008000, 24'sh001234};

   // first rows run with every register at zero, so nothing can move
   localparam stim_row_type DIRECTED [DIR_ROWS] = '{
      '{1'b0, 1'b1, '{24'sd0, 24'sd0, 24'sd0},
        '{24'sd0, 24'sd0, 24'sd0, 1'b0, 24'sd0, 23'd0, jlvsr_pkg::MODE_BRAKE}},
      '{1'b0, 1'b1, '{-24'sd1, 24'sd0, Q_MAX},
        '{24'sd0, 24'sd0, 24'sd0, 1'b0, 24'sh800001, 23'd0, jlvsr_pkg::MODE_BRAKE}},
      '{1'b0, 1'b1, '{-24'sd1, 24'sd0, Q_MIN},
        '{24'sd0, 24'sd0, 24'sd0, 1'b0, Q_MAX, 23'd0, jlvsr_pkg::MODE_BRAKE}},
      '{1'b0, 1'b1, '{Q_MAX, Q_MAX, 24'sd0},
        '{24'sd0, 24'sd0, 24'sd0, 1'b0, 24'sd0, 23'd0, jlvsr_pkg::MODE_ACCELERATE}},
      '{1'b0, 1'b1, '{Q_MIN, Q_MIN, Q_MAX},
        '{24'sd0, 24'sd0, 24'sd0, 1'b0, 24'sh800001, 23'd0, jlvsr_pkg::MODE_BRAKE}},
      // mode is still brake here, so this brake tick keeps the acceleration
      '{1'b1, 1'b0, '{-24'sh20000, 24'sh10000, 24'sh08000}, '0},
      '{1'b0, 1'b0, '{-24'sh20000, 24'sh10000, 24'sh40000}, '0},
      '{1'b0, 1'b0, '{-24'sh20000, 24'sh10000, 24'sh80000}, '0},
      '{1'b0, 1'b0, '{-24'sh20000, -24'sh10000, Q_MIN}, '0},
      '{1'b0, 1'b0, '{24'sh30000, 24'sd0, 24'sd0}, '0},
      '{1'b0, 1'b0, '{24'sh30000, 24'sd0, 24'sh10000}, '0},
      '{1'b0, 1'b0, '{24'sh30000, 24'sh200000, 24'sh20000}, '0},
      '{1'b0, 1'b0, '{24'sh30000, Q_MAX, Q_MAX}, '0},
      '{1'b0, 1'b0, '{24'sh30000, Q_MAX, Q_MAX}, '0},
      '{1'b0, 1'b0, '{24'sh30000, Q_MAX, Q_MAX}, '0},
      '{1'b0, 1'b0, '{24'sh30000, Q_MAX, 24'sh1C000}, '0},
      '{1'b0, 1'b0, '{24'sh10000, Q_MIN, 24'sh10000}, '0},
      '{1'b0, 1'b0, '{24'sh10000, Q_MIN, 24'sh10000}, '0},
      '{1'b0, 1'b0, '{24'sh10000, Q_MIN, 24'sh10000}, '0},
      '{1'b0, 1'b0, '{24'sd0, 24'sd0, 24'sh09000}, '0},
      '{1'b0, 1'b0, '{24'sd0, 24'sd0, 24'sh09000}, '0},
      '{1'b0, 1'b0, '{Q_MAX, 24'sd0, Q_MAX}, '0},
      '{1'b0, 1'b0, '{Q_MIN, Q_MIN, Q_MIN}, '0}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   jlvsr_pkg::req_type req;
   logic               rsp_valid;
   logic               rsp_ready;
   jlvsr_pkg::rsp_type rsp;
   logic               csr_valid;
   logic               csr_ready;
   logic [IDX_W-1:0]   csr_index;
   logic [23:0]        csr_data;

   jerk_limited_velocity_steer_ramp_top dut (
      .clock, .reset,
      .req_valid, .req_ready, .req,
      .rsp_valid, .rsp_ready, .rsp,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   // predictor copy of the ramp state and registers
   longint             ramp_speed  = 0;
   longint             ramp_steer  = 0;
   longint             ramp_accel  = 0;
   logic [1:0]         ramp_mode_q = jlvsr_pkg::MODE_BRAKE;
   jlvsr_pkg::cfg_type ramp_cfg    = '0;

   jlvsr_pkg::rsp_type pending_setpoints[$];
   int                 mismatches    = 0;
   int                 words_checked = 0;
   bit                 no_gaps       = 1'b0;

   function automatic longint clamp_q(longint v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v;
   endfunction

   // q16 product rounding: add half, floor
   function automatic longint round_q16(longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic jlvsr_pkg::rsp_type ramp_tick(jlvsr_pkg::req_type w);
      longint             tgt, wz, meas, dt, offs, step, lim, dv, rate, delta;
      logic [1:0]         mode;
      bit                 active, rising;
      jlvsr_pkg::rsp_type o;
      tgt    = longint'($signed(w.target_speed));
      wz     = longint'($signed(w.target_steer));
      meas   = longint'($signed(w.measured_speed));
      dt     = longint'(ramp_cfg.tick_period);
      offs   = longint'($signed(ramp_cfg.steer_offset));
      mode   = ramp_mode_q;
      active = 1'b1;
      rising = 1'b0;
      step   = 0;
      lim    = 0;
      if (tgt < 0) begin
         mode = jlvsr_pkg::MODE_BRAKE;
         step = -longint'(ramp_cfg.brake_jerk_step);
         lim  = longint'(ramp_cfg.brake_accel_limit);
      end else if (tgt > 0 && ramp_speed < 0) begin
         mode   = jlvsr_pkg::MODE_BRAKE_RELEASE;
         step   = longint'(ramp_cfg.brake_jerk_step);
         lim    = longint'(ramp_cfg.brake_accel_limit);
         rising = 1'b1;
      end else if (tgt > ramp_speed) begin
         mode   = jlvsr_pkg::MODE_ACCELERATE;
         step   = longint'(ramp_cfg.accel_jerk_step);
         lim    = longint'(ramp_cfg.accel_limit);
         rising = 1'b1;
      end else if (tgt < ramp_speed) begin
         mode = jlvsr_pkg::MODE_DECELERATE;
         step = -longint'(ramp_cfg.decel_jerk_step);
         lim  = longint'(ramp_cfg.decel_limit);
      end else begin
         active = 1'b0;
      end

      if (active) begin
         if (mode != ramp_mode_q) ramp_accel = 0;
         ramp_accel = clamp_q(ramp_accel + step);
         if (rising) begin
            if (ramp_accel > lim) ramp_accel = lim;
         end else if (ramp_accel < -lim) begin
            ramp_accel = -lim;
         end
         ramp_speed = clamp_q(ramp_speed + round_q16(ramp_accel * dt));
         // the setpoint never passes the target
         if (rising) begin
            if (ramp_speed > tgt) ramp_speed = tgt;
         end else if (ramp_speed < tgt) begin
            ramp_speed = tgt;
         end
      end
      ramp_mode_q = mode;

      // steering rate falls linearly with speed between the two bounds
      dv = meas - longint'(jlvsr_pkg::VMIN_Q);
      if (dv < 0) dv = 0;
      if (dv > longint'(jlvsr_pkg::VSPAN_Q)) dv = longint'(jlvsr_pkg::VSPAN_Q);
      rate = longint'(jlvsr_pkg::RATE_HI_Q) - round_q16(longint'(jlvsr_pkg::SLOPE_Q) * dv);
      if (rate < longint'(jlvsr_pkg::RATE_LO_Q)) rate = longint'(jlvsr_pkg::RATE_LO_Q);
      if (rate > longint'(jlvsr_pkg::RATE_HI_Q)) rate = longint'(jlvsr_pkg::RATE_HI_Q);
      delta = round_q16(rate * dt);
      if (wz > ramp_steer) begin
         ramp_steer = clamp_q(ramp_steer + delta);
         if (ramp_steer > wz) ramp_steer = wz;
      end else if (wz < ramp_steer) begin
         ramp_steer = clamp_q(ramp_steer - delta);
         if (ramp_steer < wz) ramp_steer = wz;
      end

      o.speed_setpoint = 24'(ramp_speed);
      o.accel_command  = 24'(ramp_accel);
      o.steer_command  = 24'(clamp_q(offs + ramp_steer));
      o.braking        = (ramp_speed < 0);
      o.speed_error    = 24'(clamp_q(ramp_speed - meas));
      o.forward_target = (ramp_speed > 0) ? 23'(ramp_speed) : 23'd0;
      o.ramp_mode      = ramp_mode_q;
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic jlvsr_pkg::cfg_type typical_settings(bit wide_offset);
      jlvsr_pkg::cfg_type s;
      s.brake_jerk_step   = 23'($urandom_range(32'h100, 32'h8000));
      s.brake_accel_limit = 23'($urandom_range(32'h8000, 32'h40000));
      s.accel_jerk_step   = 23'($urandom_range(32'h100, 32'h8000));
      s.accel_limit       = 23'($urandom_range(32'h8000, 32'h40000));
      s.decel_jerk_step   = 23'($urandom_range(32'h100, 32'h8000));
      s.decel_limit       = 23'($urandom_range(32'h8000, 32'h40000));
      s.tick_period       = 23'($urandom_range(32'h400, 32'h4000));
      if (wide_offset) s.steer_offset = 24'($urandom);
      else s.steer_offset = 24'(longint'($urandom_range(0, 32'h20000)) - 64'sh10000);
      return s;
   endfunction

   task automatic flag_mismatch(string what, logic [23:0] got, logic [23:0] want);
      mismatches++;
      $display("mismatch on %s, word %0d: got %h, expected %h",
               what, words_checked, got, want);
   endtask

   task automatic check_word(jlvsr_pkg::rsp_type got);
      jlvsr_pkg::rsp_type want;
      if (pending_setpoints.size() == 0) begin
         flag_mismatch("word with nothing pending", got.speed_setpoint, 24'd0);
      end else begin
         want = pending_setpoints.pop_front();
         if (got.speed_setpoint !== want.speed_setpoint)
            flag_mismatch("speed_setpoint", got.speed_setpoint, want.speed_setpoint);
         if (got.accel_command !== want.accel_command)
            flag_mismatch("accel_command", got.accel_command, want.accel_command);
         if (got.steer_command !== want.steer_command)
            flag_mismatch("steer_command", got.steer_command, want.steer_command);
         if (got.braking !== want.braking)
            flag_mismatch("braking", 24'(got.braking), 24'(want.braking));
         if (got.speed_error !== want.speed_error)
            flag_mismatch("speed_error", got.speed_error, want.speed_error);
         if (got.forward_target !== want.forward_target)
            flag_mismatch("forward_target", 24'(got.forward_target),
                          24'(want.forward_target));
         if (got.ramp_mode !== want.ramp_mode)
            flag_mismatch("ramp_mode", 24'(got.ramp_mode), 24'(want.ramp_mode));
      end
      words_checked++;
   endtask

   // leaves valid high on return so back to back words keep it up
   task automatic send_word(jlvsr_pkg::req_type w, logic typed,
                            jlvsr_pkg::rsp_type typed_rsp);
      int                 gap;
      jlvsr_pkg::rsp_type want;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req       <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      want = ramp_tick(w);
      if (typed) want = typed_rsp;
      pending_setpoints.push_back(want);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_setpoints.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(logic [IDX_W-1:0] idx, logic [23:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         jlvsr_pkg::CSR_BRAKE_JERK_STEP:   ramp_cfg.brake_jerk_step   = data[22:0];
         jlvsr_pkg::CSR_BRAKE_ACCEL_LIMIT: ramp_cfg.brake_accel_limit = data[22:0];
         jlvsr_pkg::CSR_ACCEL_JERK_STEP:   ramp_cfg.accel_jerk_step   = data[22:0];
         jlvsr_pkg::CSR_ACCEL_LIMIT:       ramp_cfg.accel_limit       = data[22:0];
         jlvsr_pkg::CSR_DECEL_JERK_STEP:   ramp_cfg.decel_jerk_step   = data[22:0];
         jlvsr_pkg::CSR_DECEL_LIMIT:       ramp_cfg.decel_limit       = data[22:0];
         jlvsr_pkg::CSR_TICK_PERIOD:       ramp_cfg.tick_period       = data[22:0];
         jlvsr_pkg::CSR_STEER_OFFSET:      ramp_cfg.steer_offset      = data;
         default: ;
      endcase
   endtask

   // top bit of the unsigned registers is junk and must be dropped
   task automatic load_settings(jlvsr_pkg::cfg_type s);
      csr_put(jlvsr_pkg::CSR_BRAKE_JERK_STEP,   {1'($urandom), s.brake_jerk_step});
      csr_put(jlvsr_pkg::CSR_BRAKE_ACCEL_LIMIT, {1'($urandom), s.brake_accel_limit});
      csr_put(jlvsr_pkg::CSR_ACCEL_JERK_STEP,   {1'($urandom), s.accel_jerk_step});
      csr_put(jlvsr_pkg::CSR_ACCEL_LIMIT,       {1'($urandom), s.accel_limit});
      csr_put(jlvsr_pkg::CSR_DECEL_JERK_STEP,   {1'($urandom), s.decel_jerk_step});
      csr_put(jlvsr_pkg::CSR_DECEL_LIMIT,       {1'($urandom), s.decel_limit});
      csr_put(jlvsr_pkg::CSR_TICK_PERIOD,       {1'($urandom), s.tick_period});
      csr_put(jlvsr_pkg::CSR_STEER_OFFSET,      s.steer_offset);
      csr_put(IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), 24'($urandom));
      csr_valid <= 1'b0;
   endtask

   // mostly runs of ticks chasing one target, with some raw noise words
   task automatic run_random(int n_items);
      int                 left, run_len, kind;
      longint             tgt, steer, meas;
      jlvsr_pkg::req_type w;
      left = n_items;
      while (left > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            w.target_speed   = 24'($urandom);
            w.target_steer   = 24'($urandom);
            w.measured_speed = 24'($urandom);
            send_word(w, 1'b0, '0);
            left--;
         end else begin
            kind = $urandom_range(0, 9);
            if (kind < 6) tgt = longint'($urandom_range(0, 32'h60000));
            else if (kind < 8) tgt = -longint'($urandom_range(1, 32'h40000));
            else if (kind == 8) tgt = 0;
            else tgt = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            steer = longint'($urandom_range(0, 32'h80000)) - 64'sh40000;
            if ($urandom_range(0, 7) == 0) steer = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            run_len = $urandom_range(1, 12);
            while (run_len > 0 && left > 0) begin
               case ($urandom_range(0, 7))
                  0:       meas = -longint'($urandom_range(0, 32'h20000));
                  1:       meas = longint'($signed(24'($urandom)));
                  default: meas = longint'($urandom_range(0, 160000));
               endcase
               w.target_speed   = 24'(tgt);
               w.target_steer   = 24'(steer);
               w.measured_speed = 24'(meas);
               send_word(w, 1'b0, '0);
               run_len--;
               left--;
            end
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : stimulus
      jlvsr_pkg::cfg_type settings;
      int                 ph;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req       <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (DIRECTED[i].reconfig) begin
            wait_drained();
            load_settings(SET_A);
         end
         send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
      end

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_drained();
         case (ph)
            0: settings = typical_settings(1'b0);
            1: begin
               settings = '1;
               settings.steer_offset = Q_MAX;
            end
            2: begin
               settings = '0;
               settings.steer_offset = Q_MIN;
            end
            3: settings = typical_settings(1'b1);
            default: begin
               settings.brake_jerk_step   = 23'($urandom);
               settings.brake_accel_limit = 23'($urandom);
               settings.accel_jerk_step   = 23'($urandom);
               settings.accel_limit       = 23'($urandom);
               settings.decel_jerk_step   = 23'($urandom);
               settings.decel_limit       = 23'($urandom);
               settings.tick_period       = 23'($urandom);
               settings.steer_offset      = 24'($urandom);
            end
         endcase
         no_gaps = (ph == 3);
         load_settings(settings);
         run_random(PHASE_ITEMS);
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("jerk_limited_velocity_steer_ramp_top regression: pass");
      end else begin
         $display("jerk_limited_velocity_steer_ramp_top regression: fail");
      end
      $finish;
   end

   initial begin : rsp_side
      int stall_left;
      int hold_left;
      bit pressure_done;
      stall_left    = 0;
      hold_left     = 0;
      pressure_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_word(rsp);
         // one long hold-off so the block backs up into its input
         if (!pressure_done && words_checked == PRESSURE_AT) begin
            hold_left     = PRESSURE_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles with no word moving", idle_cycles);
            $display("jerk_limited_velocity_steer_ramp_top regression: fail");
            $finish;
         end
      end
   end

endmodule

// File: sim.f
hdl/jlvsr_pkg.sv
hdl/jlvsr_csr.sv
hdl/jlvsr_ctrl.sv
hdl/jlvsr_datapath.sv
hdl/jerk_limited_velocity_steer_ramp_top.sv
hdl/jlvsr_checker.sv
verif/tb_jerk_limited_velocity_steer_ramp_top.sv
